FILE: sv/segi_pkg.sv
// Shared constants and types for the 3D segment intersection block.
`default_nettype none
package segi_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int T_BITS          = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int APB_AW          = 4;
    localparam int APB_DW          = 32;

    typedef enum logic [1:0] {
        REG_PARALLEL = 2'd0,
        REG_COPLANAR = 2'd1,
        REG_SIGN     = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;
endpackage
`default_nettype wire

FILE: sv/segi_if.sv
// Handshake channels for segment pairs and intersection results.
`default_nettype none
interface segi_in_if #(parameter int CW = segi_pkg::COORD_WIDTH_DEF);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by_coord;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] dz;
    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz,
                    input ready);
    modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz,
                  output ready);
endinterface

interface segi_out_if #(parameter int CW = segi_pkg::COORD_WIDTH_DEF);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic                 collinear_overlap;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    modport source (output valid, hit, collinear_overlap, px, py, pz, input ready);
    modport sink (input valid, hit, collinear_overlap, px, py, pz, output ready);
endinterface
`default_nettype wire

FILE: sv/segi_div.sv
// Pipelined restoring divider: fraction num/den with one quotient bit per stage.
`default_nettype none
module segi_div #(
    parameter int QW = 72,
    parameter int T  = 16,
    parameter int SW = 100
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [QW-1:0] i_num,
    input  wire logic [QW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [T:0]         o_q,
    output logic [SW-1:0]      o_side
);
    logic          r_v    [T+1];
    logic          r_sat  [T+1];
    logic [QW-1:0] r_rem  [T+1];
    logic [QW-1:0] r_den  [T+1];
    logic [T-1:0]  r_q    [T+1];
    logic [SW-1:0] r_side [T+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0]  <= (i_num >= i_den);
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s <= T; s++) begin : g_step
        logic [QW:0]   n_shift;
        logic          n_ge;
        logic [QW-1:0] n_rem;

        always_comb begin
            n_shift = {r_rem[s-1], 1'b0};
            n_ge    = (n_shift >= {1'b0, r_den[s-1]});
            n_rem   = n_ge ? QW'(n_shift - {1'b0, r_den[s-1]}) : QW'(n_shift);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[s]  <= r_sat[s-1];
                r_rem[s]  <= n_rem;
                r_den[s]  <= r_den[s-1];
                r_q[s]    <= T'({r_q[s-1], n_ge});
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid = r_v[T];
    assign o_q     = r_sat[T] ? {1'b1, {T{1'b0}}} : {1'b0, r_q[T]};
    assign o_side  = r_side[T];
endmodule
`default_nettype wire

FILE: sv/segment_intersection_3d.sv
// Top level: fully pipelined intersection test of two 3D segments.
// One segment pair is accepted per cycle while the output is not stalled, and its result passes
// through five stages of exact products and sums, one decision stage, an entry stage and
// one stage per quotient bit in the parameter divider, a product stage and an output
// register. A stalled output holds the whole pipeline in place.
`default_nettype none
module segment_intersection_3d #(
    parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    segi_in_if.sink                            i_in,
    segi_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [segi_pkg::APB_AW-1:0]   paddr,
    input  wire logic [segi_pkg::APB_DW-1:0]   pwdata,
    output logic      [segi_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import segi_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * CW + 2;
    localparam int XW  = 2 * CW + 3;
    localparam int SW2 = 2 * CW + 4;
    localparam int QW  = 4 * CW + 8;
    localparam int TW  = 3 * CW + 6;
    localparam int T   = T_BITS;
    localparam int MW  = DW + T + 2;
    localparam int OW  = MW - T + 1;
    localparam int SDW = 2 + 3 * DW + 3 * CW;

    // configuration
    logic [CFG_WIDTH-1:0] r_par, r_cop, r_sgn;
    t_reg_idx             cfg_idx;

    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par <= '0;
            r_cop <= '0;
            r_sgn <= '0;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_PARALLEL: r_par <= pwdata[CFG_WIDTH-1:0];
                REG_COPLANAR: r_cop <= pwdata[CFG_WIDTH-1:0];
                REG_SIGN:     r_sgn <= pwdata[CFG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PARALLEL: prdata = APB_DW'(r_par);
            REG_COPLANAR: prdata = APB_DW'(r_cop);
            REG_SIGN:     prdata = APB_DW'(r_sgn);
            default:      prdata = '0;
        endcase
    end

    // pipeline control
    logic r_out_valid;
    logic en;
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    logic signed [CW-1:0] in_a [3], in_b [3], in_c [3], in_d [3];
    always_comb begin
        in_a[0] = i_in.ax; in_a[1] = i_in.ay;       in_a[2] = i_in.az;
        in_b[0] = i_in.bx; in_b[1] = i_in.by_coord; in_b[2] = i_in.bz;
        in_c[0] = i_in.cx; in_c[1] = i_in.cy;       in_c[2] = i_in.cz;
        in_d[0] = i_in.dx; in_d[1] = i_in.dy;       in_d[2] = i_in.dz;
    end

    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid && i_in.ready;
            r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v; r5_v <= r4_v; r6_v <= r5_v;
        end
    end

    // stage 1: difference vectors
    logic signed [DW-1:0] r1_ab [3], r1_cd [3], r1_ac [3], r1_ad [3];
    logic signed [CW-1:0] r1_a  [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_ab[k] <= DW'(in_b[k]) - DW'(in_a[k]);
                r1_cd[k] <= DW'(in_d[k]) - DW'(in_c[k]);
                r1_ac[k] <= DW'(in_c[k]) - DW'(in_a[k]);
                r1_ad[k] <= DW'(in_d[k]) - DW'(in_a[k]);
                r1_a[k]  <= in_a[k];
            end
        end
    end

    // stage 2: cross and dot partial products
    logic signed [PW-1:0] r2_np [6], r2_mp [6], r2_wp [6];
    logic signed [PW-1:0] r2_abab [3], r2_acab [3], r2_adab [3];
    logic signed [DW-1:0] r2_ab [3], r2_ac [3];
    logic signed [CW-1:0] r2_a  [3];
    logic                 r2_zero;

    for (genvar k = 0; k < 3; k++) begin : g_s2
        localparam int I1 = (k + 1) % 3;
        localparam int I2 = (k + 2) % 3;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r2_np[2*k]   <= PW'(r1_ab[I1]) * PW'(r1_cd[I2]);
                r2_np[2*k+1] <= PW'(r1_ab[I2]) * PW'(r1_cd[I1]);
                r2_mp[2*k]   <= PW'(r1_ac[I1]) * PW'(r1_ab[I2]);
                r2_mp[2*k+1] <= PW'(r1_ac[I2]) * PW'(r1_ab[I1]);
                r2_wp[2*k]   <= PW'(r1_ac[I1]) * PW'(r1_cd[I2]);
                r2_wp[2*k+1] <= PW'(r1_ac[I2]) * PW'(r1_cd[I1]);
                r2_abab[k]   <= PW'(r1_ab[k]) * PW'(r1_ab[k]);
                r2_acab[k]   <= PW'(r1_ac[k]) * PW'(r1_ab[k]);
                r2_adab[k]   <= PW'(r1_ad[k]) * PW'(r1_ab[k]);
                r2_ab[k]     <= r1_ab[k];
                r2_ac[k]     <= r1_ac[k];
                r2_a[k]      <= r1_a[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_zero <= (r1_ab[0] == '0) && (r1_ab[1] == '0) && (r1_ab[2] == '0);
        end
    end

    // stage 3: cross products and dot products
    logic signed [XW-1:0]  r3_n [3], r3_m [3], r3_w [3];
    logic signed [SW2-1:0] r3_den, r3_d0, r3_d1;
    logic signed [DW-1:0]  r3_ab [3], r3_ac [3];
    logic signed [CW-1:0]  r3_a  [3];
    logic                  r3_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r3_n[k]  <= XW'(r2_np[2*k]) - XW'(r2_np[2*k+1]);
                r3_m[k]  <= XW'(r2_mp[2*k]) - XW'(r2_mp[2*k+1]);
                r3_w[k]  <= XW'(r2_wp[2*k]) - XW'(r2_wp[2*k+1]);
                r3_ab[k] <= r2_ab[k];
                r3_ac[k] <= r2_ac[k];
                r3_a[k]  <= r2_a[k];
            end
            r3_den  <= SW2'(r2_abab[0]) + SW2'(r2_abab[1]) + SW2'(r2_abab[2]);
            r3_d0   <= SW2'(r2_acab[0]) + SW2'(r2_acab[1]) + SW2'(r2_acab[2]);
            r3_d1   <= SW2'(r2_adab[0]) + SW2'(r2_adab[1]) + SW2'(r2_adab[2]);
            r3_zero <= r2_zero;
        end
    end

    // stage 4: products against n, squares of m
    logic signed [QW-1:0]  r4_nn [3], r4_mm [3], r4_tn [3], r4_un [3];
    logic signed [TW-1:0]  r4_tr [3];
    logic signed [SW2-1:0] r4_den, r4_lo, r4_hi;
    logic signed [DW-1:0]  r4_ab [3];
    logic signed [CW-1:0]  r4_a  [3];
    logic                  r4_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r4_nn[k] <= QW'(r3_n[k]) * QW'(r3_n[k]);
                r4_mm[k] <= QW'(r3_m[k]) * QW'(r3_m[k]);
                r4_tn[k] <= QW'(r3_w[k]) * QW'(r3_n[k]);
                r4_un[k] <= QW'(r3_m[k]) * QW'(r3_n[k]);
                r4_tr[k] <= TW'(r3_ac[k]) * TW'(r3_n[k]);
                r4_ab[k] <= r3_ab[k];
                r4_a[k]  <= r3_a[k];
            end
            r4_den  <= r3_den;
            r4_lo   <= (r3_d0 <= r3_d1) ? r3_d0 : r3_d1;
            r4_hi   <= (r3_d0 <= r3_d1) ? r3_d1 : r3_d0;
            r4_zero <= r3_zero;
        end
    end

    // stage 5: sums
    logic signed [QW-1:0]  r5_q0, r5_mm, r5_tn, r5_un;
    logic signed [TW-1:0]  r5_tr;
    logic signed [SW2-1:0] r5_den, r5_lo, r5_hi;
    logic signed [DW-1:0]  r5_ab [3];
    logic signed [CW-1:0]  r5_a  [3];
    logic                  r5_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_q0   <= r4_nn[0] + r4_nn[1] + r4_nn[2];
            r5_mm   <= r4_mm[0] + r4_mm[1] + r4_mm[2];
            r5_tn   <= r4_tn[0] + r4_tn[1] + r4_tn[2];
            r5_un   <= -(r4_un[0] + r4_un[1] + r4_un[2]);
            r5_tr   <= r4_tr[0] + r4_tr[1] + r4_tr[2];
            r5_den  <= r4_den;
            r5_lo   <= r4_lo;
            r5_hi   <= r4_hi;
            r5_ab   <= r4_ab;
            r5_a    <= r4_a;
            r5_zero <= r4_zero;
        end
    end

    // stage 6: case decision
    logic signed [QW-1:0] ptol, band, lo_w, hi_w, den_w, tr_w, tr_abs, cop_w;
    logic                 n_coll, c_ok, g_ok, n_hit;
    logic [QW-1:0]        n_num, n_den;

    always_comb begin
        ptol   = $signed(QW'(r_par));
        cop_w  = $signed(QW'(r_cop));
        band   = -$signed(QW'(r_sgn));
        lo_w   = QW'(r5_lo);
        hi_w   = QW'(r5_hi);
        den_w  = QW'(r5_den);
        tr_w   = QW'(r5_tr);
        tr_abs = tr_w[QW-1] ? -tr_w : tr_w;
        n_coll = (r5_q0 <= ptol);
        c_ok   = (r5_mm <= ptol) && (lo_w <= den_w) && !hi_w[QW-1];
        g_ok   = (tr_abs <= cop_w) && (r5_tn >= band) && (r5_tn <= r5_q0)
                 && (r5_un >= band) && (r5_un <= r5_q0);
        n_hit  = !r5_zero && (n_coll ? c_ok : g_ok);
        if (n_coll) begin
            n_num = lo_w[QW-1] ? '0 : lo_w;
            n_den = den_w;
        end else begin
            n_num = r5_tn[QW-1] ? '0 : r5_tn;
            n_den = r5_q0;
        end
    end

    logic [QW-1:0]        r6_num, r6_den;
    logic                 r6_hit, r6_coll;
    logic signed [DW-1:0] r6_ab [3];
    logic signed [CW-1:0] r6_a  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_num  <= n_num;
            r6_den  <= n_den;
            r6_hit  <= n_hit;
            r6_coll <= n_coll;
            r6_ab   <= r5_ab;
            r6_a    <= r5_a;
        end
    end

    // parameter along AB
    logic [SDW-1:0] div_side_in, div_side_out;
    logic           div_v;
    logic [T:0]     div_q;

    assign div_side_in = {r6_hit, r6_coll, r6_ab[0], r6_ab[1], r6_ab[2],
                          r6_a[0], r6_a[1], r6_a[2]};

    segi_div #(.QW(QW), .T(T), .SW(SDW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num   (r6_num),
        .i_den   (r6_den),
        .i_side  (div_side_in),
        .o_valid (div_v),
        .o_q     (div_q),
        .o_side  (div_side_out)
    );

    logic                 d_hit, d_coll;
    logic signed [DW-1:0] d_ab [3];
    logic signed [CW-1:0] d_a  [3];
    assign {d_hit, d_coll, d_ab[0], d_ab[1], d_ab[2], d_a[0], d_a[1], d_a[2]} = div_side_out;

    // stage 7: offset products
    logic signed [MW-1:0] r7_p [3];
    logic signed [CW-1:0] r7_a [3];
    logic                 r7_hit, r7_coll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r7_p[k] <= MW'(d_ab[k]) * $signed(MW'(div_q));
                r7_a[k] <= d_a[k];
            end
            r7_hit  <= d_hit;
            r7_coll <= d_coll;
        end
    end

    // output stage: round, offset, saturate
    localparam logic signed [OW-1:0] P_HI = OW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [OW-1:0] P_LO = -P_HI - OW'(1);

    logic signed [MW-1:0] n_x   [3];
    logic signed [OW-1:0] n_p   [3];
    logic signed [CW-1:0] n_sat [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_x[k] = r7_p[k] + (MW'(1) <<< (T - 1));
            n_p[k] = OW'(r7_a[k]) + OW'(n_x[k] >>> T);
            if (n_p[k] > P_HI) begin
                n_sat[k] = CW'(P_HI);
            end else if (n_p[k] < P_LO) begin
                n_sat[k] = CW'(P_LO);
            end else begin
                n_sat[k] = CW'(n_p[k]);
            end
        end
    end

    logic                 r_hit, r_coll;
    logic signed [CW-1:0] r_pt [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit  <= r7_hit;
            r_coll <= r7_hit && r7_coll;
            for (int k = 0; k < 3; k++) begin
                r_pt[k] <= r7_hit ? n_sat[k] : '0;
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.hit               = r_hit;
    assign o_out.collinear_overlap = r_coll;
    assign o_out.px                = r_pt[0];
    assign o_out.py                = r_pt[1];
    assign o_out.pz                = r_pt[2];

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.hit |->
            o_out.px == '0 && o_out.py == '0 && o_out.pz == '0 && !o_out.collinear_overlap)
        else $error("miss result carries a nonzero point");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while output stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.px) && $stable(o_out.hit))
        else $error("stalled result changed");
endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for segment_intersection_3d with an exact-integer intersection predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import segi_pkg::*;

    typedef logic signed [127:0] t_wide;
    typedef t_wide t_vec3 [3];

    typedef struct {
        shortint ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz;
    } t_seg_pair;

    typedef struct {
        bit      hit;
        bit      coll;
        shortint px, py, pz;
    } t_meet;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    segi_in_if  #(16) in_ch ();
    segi_out_if #(16) out_ch ();

    segment_intersection_3d uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    logic [15:0] par_thr = '0, cop_thr = '0, sgn_thr = '0;
    t_seg_pair pending_pairs [$];
    t_meet     expected_meets [$];
    int        errors = 0;
    int        cycles = 0;
    bit        rx_block_req = 0;

    function automatic t_vec3 cross3(t_vec3 a, t_vec3 b);
        t_vec3 r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic t_wide dot3(t_vec3 a, t_vec3 b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic shortint place_coord(int a, int d, longint q);
        longint x, p;
        x = longint'(d) * q + 64'sd32768;
        p = a + (x >>> 16);
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return shortint'(p);
    endfunction

    function automatic t_meet predict_intersection(t_seg_pair s);
        t_meet r;
        int a [3], b [3], c [3], d [3];
        t_vec3 vab, vcd, vac, vad, n, m;
        t_wide par, cop, band, q0, den, tnum, d0, d1, lo, hi, trip, tn, un;
        longint q;
        r = '{0, 0, 0, 0, 0};
        par = {112'd0, par_thr};
        cop = {112'd0, cop_thr};
        band = -t_wide'({112'd0, sgn_thr});
        a = '{s.ax, s.ay, s.az};
        b = '{s.bx, s.by_coord, s.bz};
        c = '{s.cx, s.cy, s.cz};
        d = '{s.dx, s.dy, s.dz};
        for (int i = 0; i < 3; i++) begin
            vab[i] = t_wide'(b[i] - a[i]);
            vcd[i] = t_wide'(d[i] - c[i]);
            vac[i] = t_wide'(c[i] - a[i]);
            vad[i] = t_wide'(d[i] - a[i]);
        end
        if (vab[0] == 0 && vab[1] == 0 && vab[2] == 0) return r;
        n = cross3(vab, vcd);
        q0 = dot3(n, n);
        if (q0 <= par) begin
            m = cross3(vac, vab);
            if (dot3(m, m) > par) return r;
            den = dot3(vab, vab);
            d0 = dot3(vac, vab);
            d1 = dot3(vad, vab);
            lo = (d0 <= d1) ? d0 : d1;
            hi = (d0 <= d1) ? d1 : d0;
            if (lo > den || hi < 0) return r;
            tnum = (lo < 0) ? 0 : lo;
            r.coll = 1;
        end else begin
            trip = dot3(vac, n);
            if (trip < 0) trip = -trip;
            if (trip > cop) return r;
            den = q0;
            tn = dot3(cross3(vac, vcd), n);
            un = -dot3(cross3(vac, vab), n);
            if (tn < band || tn > den) return r;
            if (un < band || un > den) return r;
            tnum = (tn < 0) ? 0 : tn;
        end
        if (tnum >= den) q = 65536;
        else q = longint'((tnum <<< 16) / den);
        r.hit = 1;
        r.px = place_coord(a[0], b[0] - a[0], q);
        r.py = place_coord(a[1], b[1] - a[1], q);
        r.pz = place_coord(a[2], b[2] - a[2], q);
        return r;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    bit in_taken = 0;
    int tx_gap = 0, tx_quiet = 0;
    always @(posedge i_clk) begin
        in_taken <= in_ch.valid && in_ch.ready;
        if (in_ch.valid && in_ch.ready)
            expected_meets.push_back(predict_intersection('{in_ch.ax, in_ch.ay, in_ch.az,
                in_ch.bx, in_ch.by_coord, in_ch.bz, in_ch.cx, in_ch.cy, in_ch.cz,
                in_ch.dx, in_ch.dy, in_ch.dz}));
    end

    initial begin
        in_ch.valid = 0;
        {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by_coord, in_ch.bz} = '0;
        {in_ch.cx, in_ch.cy, in_ch.cz, in_ch.dx, in_ch.dy, in_ch.dz} = '0;
    end

    always @(negedge i_clk) begin
        t_seg_pair s;
        if (i_rst_n && !(in_ch.valid && !in_taken)) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                s = pending_pairs.pop_front();
                in_ch.ax <= s.ax; in_ch.ay <= s.ay; in_ch.az <= s.az;
                in_ch.bx <= s.bx; in_ch.by_coord <= s.by_coord; in_ch.bz <= s.bz;
                in_ch.cx <= s.cx; in_ch.cy <= s.cy; in_ch.cz <= s.cz;
                in_ch.dx <= s.dx; in_ch.dy <= s.dy; in_ch.dz <= s.dz;
                in_ch.valid <= 1'b1;
                if (tx_quiet > 0) begin
                    tx_quiet <= tx_quiet - 1;
                    tx_gap <= 0;
                end else begin
                    if ($urandom_range(0, 19) == 0) tx_quiet <= 30;
                    tx_gap <= pick_gap();
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver
    int rx_gap = 0, rx_quiet = 0, rx_block = 0;
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (rx_block_req) begin
            rx_block_req = 0;
            rx_block = 300;
        end
        if (rx_block > 0) begin
            rx_block--;
            out_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (rx_quiet > 0) rx_quiet--;
            else begin
                if ($urandom_range(0, 19) == 0) rx_quiet = 30;
                rx_gap = pick_gap();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_meet e;
        cycles <= cycles + 1;
        if (cycles > 300000) begin
            $display("segment_intersection_3d: mismatch");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_meets.size() == 0) begin
                $display("%0t: unexpected transaction hit=%0b", $time, out_ch.hit);
                errors++;
            end else begin
                e = expected_meets.pop_front();
                if (out_ch.hit !== e.hit || out_ch.collinear_overlap !== e.coll ||
                    out_ch.px !== e.px || out_ch.py !== e.py || out_ch.pz !== e.pz) begin
                    $display({"%0t: expected hit=%0b coll=%0b p=(%0d,%0d,%0d)",
                              " got %0b %0b (%0d,%0d,%0d)"},
                             $time, e.hit, e.coll, e.px, e.py, e.pz, out_ch.hit,
                             out_ch.collinear_overlap, out_ch.px, out_ch.py, out_ch.pz);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= APB_AW'(idx) << 2;
        pwdata <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_PARALLEL: par_thr = value;
            REG_COPLANAR: cop_thr = value;
            REG_SIGN:     sgn_thr = value;
            default: ;
        endcase
    endtask

    task automatic set_thresholds(logic [15:0] p, logic [15:0] c, logic [15:0] s);
        write_reg(REG_PARALLEL, p);
        write_reg(REG_COPLANAR, c);
        write_reg(REG_SIGN, s);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_pairs.size() != 0 || in_ch.valid || expected_meets.size() != 0);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic t_seg_pair mk(int ax, int ay, int az, int bx, int by_c, int bz,
                                     int cx, int cy, int cz, int dx, int dy, int dz);
        return '{shortint'(ax), shortint'(ay), shortint'(az), shortint'(bx), shortint'(by_c),
                 shortint'(bz), shortint'(cx), shortint'(cy), shortint'(cz), shortint'(dx),
                 shortint'(dy), shortint'(dz)};
    endfunction

    function automatic t_seg_pair random_pair();
        int a [3], ab [3], p [3], e [3], k, j, r, sel;
        sel = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            a[i] = $urandom_range(0, 16000) - 8000;
            ab[i] = ($urandom_range(0, 256) - 128) * 16;
            e[i] = $urandom_range(0, 4000) - 2000;
        end
        if (sel < 45) begin
            k = $urandom_range(0, 16);
            r = $urandom_range(1, 3);
            for (int i = 0; i < 3; i++) p[i] = a[i] + ab[i] * k / 16;
            if ($urandom_range(0, 3) == 0) p[$urandom_range(0, 2)] += $urandom_range(0, 8) - 4;
            return mk(a[0], a[1], a[2], a[0] + ab[0], a[1] + ab[1], a[2] + ab[2],
                      p[0] - e[0], p[1] - e[1], p[2] - e[2],
                      p[0] + e[0] * r, p[1] + e[1] * r, p[2] + e[2] * r);
        end else if (sel < 75) begin
            for (int i = 0; i < 3; i++) ab[i] = ab[i] / 4;
            j = $urandom_range(0, 4) - 2;
            k = $urandom_range(0, 4) - 1;
            r = (sel < 65) ? 0 : $urandom_range(1, 40);
            return mk(a[0], a[1], a[2], a[0] + ab[0], a[1] + ab[1], a[2] + ab[2],
                      a[0] + ab[0] * j + r, a[1] + ab[1] * j, a[2] + ab[2] * j,
                      a[0] + ab[0] * k + r, a[1] + ab[1] * k, a[2] + ab[2] * k);
        end
        return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic queue_random(int count);
        repeat (count) pending_pairs.push_back(random_pair());
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;
        set_thresholds(16'd0, 16'd0, 16'd0);
        // zero-length AB
        pending_pairs.push_back(mk(100, 200, 300, 100, 200, 300, 0, 0, 0, 500, 500, 500));
        // crossing at midpoint, at endpoints, just past the end, and stopping just short of AB
        pending_pairs.push_back(mk(0, 0, 0, 512, 0, 0, 256, -256, 0, 256, 256, 0));
        pending_pairs.push_back(mk(0, 0, 0, 512, 0, 0, 0, -256, 0, 0, 256, 0));
        pending_pairs.push_back(mk(0, 0, 0, 512, 0, 0, 512, 0, 0, 512, 256, 0));
        pending_pairs.push_back(mk(0, 0, 0, 512, 0, 0, 513, -256, 0, 513, 256, 0));
        pending_pairs.push_back(mk(0, 0, 0, 512, 0, 0, 256, 1, 0, 256, 256, 0));
        // skew lines
        pending_pairs.push_back(mk(0, 0, 0, 512, 0, 0, 256, -256, 10, 256, 256, 10));
        // collinear overlap, reversed order, touching, disjoint, parallel offset, point-like CD on AB
        pending_pairs.push_back(mk(0, 0, 0, 512, 512, 512, 256, 256, 256, 1024, 1024, 1024));
        pending_pairs.push_back(mk(0, 0, 0, 512, 512, 512, 1024, 1024, 1024, -256, -256, -256));
        pending_pairs.push_back(mk(0, 0, 0, 512, 512, 512, -512, -512, -512, 0, 0, 0));
        pending_pairs.push_back(mk(0, 0, 0, 512, 512, 512, 600, 600, 600, 900, 900, 900));
        pending_pairs.push_back(mk(0, 0, 0, 512, 512, 512, 1, 0, 0, 513, 512, 512));
        pending_pairs.push_back(mk(0, 0, 0, 512, 512, 512, 100, 100, 100, 100, 100, 100));
        // extreme coordinates
        pending_pairs.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                                   32767, -32768, 0, -32768, 32767, 0));
        pending_pairs.push_back(mk(-32768, 0, 0, 32767, 0, 0, 0, -32768, 0, 0, 32767, 0));
        pending_pairs.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
                                   32767, 32767, 32767, -32768, -32768, -32768));
        pending_pairs.push_back(mk(-32768, -32768, -32768, -32768, -32768, 32767,
                                   32767, 32767, 32767, -32768, -32768, -32768));
        queue_random(150);
        drain();
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(130);
        drain();
        set_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
        rx_block_req = 1;
        queue_random(130);
        drain();
        set_thresholds(16'd0, 16'd1000, 16'd300);
        queue_random(130);
        drain();
        if (errors == 0) $display("segment_intersection_3d: match");
        else $display("segment_intersection_3d: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
